>>> rtl/integer_to_decimal_text_unit_assert.svh
// ----------------------------------------------------------------------------
// integer_to_decimal_text_unit assertion macros
// clocked assertion wrappers used by the checker file itdt_chk
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_DECIMAL_TEXT_UNIT_ASSERT_SVH
`define INTEGER_TO_DECIMAL_TEXT_UNIT_ASSERT_SVH

// checked only while out of reset
`define ITDT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ITDT_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/itdt_pkg.sv
// ----------------------------------------------------------------------------
// itdt_pkg
// shared types and constants of the decimal text unit
// ----------------------------------------------------------------------------
package itdt_pkg;

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;
    localparam logic [6:0] CHAR_NINE  = 7'h39;
    localparam logic [6:0] CHAR_FAIL  = 7'h00;
    localparam logic [3:0] MAX_ROOM   = 4'd12;

    // per-item control carried along the cell chain
    typedef struct packed {
        logic       valid;
        logic       neg;
        logic [3:0] room;
    } t_ctl;

endpackage

>>> rtl/itdt_in_if.sv
// ----------------------------------------------------------------------------
// itdt_in_if
// input channel: one value to convert per transfer
// ----------------------------------------------------------------------------
interface itdt_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_bits;
    logic        is_signed;
    logic [3:0]  buffer_len;

    modport source (output valid, output value_bits, output is_signed,
                    output buffer_len, input ready);
    modport sink   (input valid, input value_bits, input is_signed,
                    input buffer_len, output ready);
endinterface

>>> rtl/itdt_out_if.sv
// ----------------------------------------------------------------------------
// itdt_out_if
// output channel: one character per transfer
// ----------------------------------------------------------------------------
interface itdt_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       status;
    logic       last;

    modport source (output valid, output char_code, output status,
                    output last, input ready);
    modport sink   (input valid, input char_code, input status,
                    input last, output ready);
    modport mon    (input valid, input char_code, input status,
                    input last, input ready);
endinterface

>>> rtl/itdt_cell.sv
// ----------------------------------------------------------------------------
// itdt_cell
// one shift-and-add-3 step of the binary to bcd chain
// ----------------------------------------------------------------------------
module itdt_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int NUM_DIGITS  = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  itdt_pkg::t_ctl            i_ctl,
    input  logic [VALUE_WIDTH-1:0]    i_bin,
    input  logic [4*NUM_DIGITS-1:0]   i_bcd,
    output itdt_pkg::t_ctl            o_ctl,
    output logic [VALUE_WIDTH-1:0]    o_bin,
    output logic [4*NUM_DIGITS-1:0]   o_bcd
);

    itdt_pkg::t_ctl            r_ctl;
    logic [VALUE_WIDTH-1:0]    r_bin, n_bin;
    logic [4*NUM_DIGITS-1:0]   r_bcd, n_bcd;
    logic [4*NUM_DIGITS-1:0]   w_adj;

    // add 3 to every digit of 5 or more, then shift in the next bit
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            w_adj[4*d +: 4] = (i_bcd[4*d +: 4] >= 4'd5) ? i_bcd[4*d +: 4] + 4'd3
                                                        : i_bcd[4*d +: 4];
        end
        n_bcd = {w_adj[4*NUM_DIGITS-2:0], i_bin[VALUE_WIDTH-1]};
        n_bin = {i_bin[VALUE_WIDTH-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
    end

    assign o_ctl = r_ctl;
    assign o_bin = r_bin;
    assign o_bcd = r_bcd;

endmodule

>>> rtl/itdt_ser.sv
// ----------------------------------------------------------------------------
// itdt_ser
// length check and character serializer at the end of the chain
// ----------------------------------------------------------------------------
module itdt_ser #(
    parameter int NUM_DIGITS = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  itdt_pkg::t_ctl          i_ctl,
    input  logic [4*NUM_DIGITS-1:0] i_bcd,
    output logic                    o_free,
    itdt_out_if.source              o_out
);

    localparam int NW = $clog2(NUM_DIGITS + 1);
    localparam int PW = $clog2(NUM_DIGITS);
    localparam int CW = (NW + 1 > 4) ? NW + 1 : 4;

    logic                    r_active, n_active;
    logic                    r_fail, n_fail;
    logic                    r_sign, n_sign;
    logic [PW-1:0]           r_pos, n_pos;
    logic [4*NUM_DIGITS-1:0] r_bcd, n_bcd;
    logic [NW-1:0]           w_nd;
    logic [CW-1:0]           w_len;
    logic                    w_fail;
    logic                    w_last;
    logic                    w_load;
    logic [3:0]              w_digit;

    // digit count, leading zeros blanked, at least one
    always_comb begin
        w_nd = NW'(1);
        for (int d = 1; d < NUM_DIGITS; d++) begin
            if (i_bcd[4*d +: 4] != 4'd0) begin
                w_nd = NW'(d + 1);
            end
        end
        w_len  = CW'(w_nd) + CW'(i_ctl.neg);
        w_fail = (i_ctl.room == 4'd0) || (w_len >= CW'(i_ctl.room));
    end

    assign w_last  = r_fail || (!r_sign && (r_pos == PW'(0)));
    assign o_free  = !r_active || (o_out.ready && w_last);
    assign w_load  = i_ctl.valid && o_free;
    assign w_digit = r_bcd[4*r_pos +: 4];

    always_comb begin
        n_active = r_active;
        n_fail   = r_fail;
        n_sign   = r_sign;
        n_pos    = r_pos;
        n_bcd    = r_bcd;
        if (w_load) begin
            n_active = 1'b1;
            n_fail   = w_fail;
            n_sign   = i_ctl.neg;
            n_pos    = PW'(w_nd - NW'(1));
            n_bcd    = i_bcd;
        end else if (r_active && o_out.ready) begin
            if (w_last) begin
                n_active = 1'b0;
            end else if (r_sign) begin
                n_sign = 1'b0;
            end else begin
                n_pos = r_pos - PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fail <= n_fail;
        r_sign <= n_sign;
        r_pos  <= n_pos;
        r_bcd  <= n_bcd;
    end

    assign o_out.valid     = r_active;
    assign o_out.status    = r_fail;
    assign o_out.last      = w_last;
    assign o_out.char_code = r_fail ? itdt_pkg::CHAR_FAIL
                           : r_sign ? itdt_pkg::CHAR_MINUS
                           : itdt_pkg::CHAR_ZERO + {3'b000, w_digit};

endmodule

>>> rtl/integer_to_decimal_text_unit.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_text_unit
// decimal ascii text of a signed or unsigned integer, one character per transfer
// ----------------------------------------------------------------------------
// A value enters a chain of VALUE_WIDTH shift-and-add-3 cells, one cell per
// input bit, and its digits are ready once it leaves the last cell; the chain
// takes a new value in every cycle in which it moves. The serializer at the
// end then sends the text at one character per cycle while the receiver is
// ready: an optional minus sign and the digits, 1 to 11 transfers at a width
// of 32, or a single failure transfer (status 1, char_code 0) when the text
// and its terminator do not fit in buffer_len (values above 12 count as 12).
// The serializer sets the sustained rate: it loads the next value as the last
// character of the previous text is taken; the chain stalls as a whole while
// the serializer is still busy and the last cell is occupied.
// ----------------------------------------------------------------------------
module integer_to_decimal_text_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itdt_in_if.sink    i_in,
    itdt_out_if.source o_out
);

    // decimal digits needed for VALUE_WIDTH bits
    localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;

    itdt_pkg::t_ctl          w_ctl [0:VALUE_WIDTH];
    logic [VALUE_WIDTH-1:0]  w_bin [0:VALUE_WIDTH];
    logic [4*NUM_DIGITS-1:0] w_bcd [0:VALUE_WIDTH];
    logic [VALUE_WIDTH-1:0]  w_val;
    logic                    w_neg;
    logic                    w_adv;
    logic                    w_free;

    // value at the configured width
    generate
        if (VALUE_WIDTH <= 32) begin : g_narrow
            assign w_val = i_in.value_bits[VALUE_WIDTH-1:0];
        end else begin : g_wide
            assign w_val = {{(VALUE_WIDTH-32){1'b0}}, i_in.value_bits};
        end
    endgenerate

    // sign and magnitude; the most negative value keeps its full magnitude
    assign w_neg         = i_in.is_signed && w_val[VALUE_WIDTH-1];
    assign w_bin[0]      = w_neg ? (~w_val + VALUE_WIDTH'(1)) : w_val;
    assign w_bcd[0]      = '0;
    assign w_ctl[0].valid = i_in.valid;
    assign w_ctl[0].neg   = w_neg;
    assign w_ctl[0].room  = (i_in.buffer_len > itdt_pkg::MAX_ROOM) ? itdt_pkg::MAX_ROOM
                                                                   : i_in.buffer_len;

    // whole chain moves when its last cell is empty or hands over
    assign w_adv      = !w_ctl[VALUE_WIDTH].valid || w_free;
    assign i_in.ready = w_adv;

    generate
        for (genvar c = 0; c < VALUE_WIDTH; c++) begin : g_cell
            itdt_cell #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .NUM_DIGITS  (NUM_DIGITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_ctl   (w_ctl[c]),
                .i_bin   (w_bin[c]),
                .i_bcd   (w_bcd[c]),
                .o_ctl   (w_ctl[c+1]),
                .o_bin   (w_bin[c+1]),
                .o_bcd   (w_bcd[c+1])
            );
        end
    endgenerate

    // binary remainder of the last cell is all zero and left unused there
    itdt_ser #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl[VALUE_WIDTH]),
        .i_bcd   (w_bcd[VALUE_WIDTH]),
        .o_free  (w_free),
        .o_out   (o_out)
    );

endmodule

>>> rtl/itdt_chk.sv
// ----------------------------------------------------------------------------
// itdt_chk
// port-level checks of the decimal text unit output
// ----------------------------------------------------------------------------
`include "integer_to_decimal_text_unit_assert.svh"

module itdt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    itdt_out_if.source i_out
);

    logic       w_fail_shown;
    logic       w_fail_form;
    logic       w_text_shown;
    logic       w_is_minus;
    logic       w_is_digit;
    logic       w_text_char;
    logic       w_mid_xfer;
    logic       w_body;
    logic       w_stall;
    logic [8:0] w_payload;

    assign w_fail_shown = i_out.valid && i_out.status;
    assign w_fail_form  = i_out.last && (i_out.char_code == itdt_pkg::CHAR_FAIL);
    assign w_text_shown = i_out.valid && !i_out.status;
    assign w_is_minus   = (i_out.char_code == itdt_pkg::CHAR_MINUS);
    assign w_is_digit   = (i_out.char_code >= itdt_pkg::CHAR_ZERO) &&
                          (i_out.char_code <= itdt_pkg::CHAR_NINE);
    assign w_text_char  = w_is_minus || w_is_digit;
    // a transfer that does not end its text
    assign w_mid_xfer   = i_out.valid && i_out.ready && !i_out.last;
    assign w_body       = i_out.valid && !w_is_minus;
    assign w_stall      = i_out.valid && !i_out.ready;
    assign w_payload    = {i_out.char_code, i_out.status, i_out.last};

    `ITDT_ASSERT_RST(a_reset_idle, !i_rst_n |=> !i_out.valid, "output valid right after reset")

    `ITDT_ASSERT(a_fail_form, w_fail_shown |-> w_fail_form, "malformed failure transfer")

    `ITDT_ASSERT(a_char_set, w_text_shown |-> w_text_char, "character outside sign and digits")

    `ITDT_ASSERT(a_text_cont, w_mid_xfer |=> w_body, "text broken or sign not first")

    `ITDT_ASSERT(a_hold, w_stall |=> (i_out.valid && $stable(w_payload)), "stalled transfer changed")

endmodule

bind integer_to_decimal_text_unit itdt_chk u_itdt_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_out   (o_out)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the decimal text unit character by character against a behavioral
// predictor under random valid and ready gaps, back-to-back runs and a drain
// ----------------------------------------------------------------------------
module testbench;

    localparam int VALUE_WIDTH = 32;
    // digits pass one cell per bit, then up to eleven characters leave
    localparam int SETTLE_CYCLES = VALUE_WIDTH + 24;
    // 364 values at eleven characters each, both sides stalling, many times over
    localparam int RUN_LIMIT_NS = 3_000_000;

    // one expected character transfer on the output channel
    typedef struct packed {
        logic [6:0] char_code;
        logic       status;
        logic       last;
    } t_text_char;

    logic i_clk;
    logic i_rst_n;

    itdt_in_if  in_if ();
    itdt_out_if out_if ();

    // characters predicted for accepted values, oldest first
    t_text_char  text_chars_pending[$];
    int unsigned mismatch_count;

    // random idling of the sender and the receiver, switched per test
    bit tx_idle_on;
    bit rx_idle_on;

    integer_to_decimal_text_unit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // 12 ns period
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // --------------------------------------------------------------------
    // predictor: decimal text of one value, or the single failure character
    // --------------------------------------------------------------------
    function automatic void predict_text(input logic [31:0] value, input logic sgn,
                                         input logic [3:0] len, ref t_text_char chars[$]);
        logic [63:0] mask;
        logic [63:0] v;
        logic [63:0] mag;
        logic        neg;
        logic [6:0]  digits[$];
        int unsigned room;
        int unsigned text_len;
        mask = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
        v    = {32'd0, value} & mask;
        neg  = sgn && v[VALUE_WIDTH-1];
        // the most negative value wraps to its own magnitude, which is right
        mag  = neg ? ((~v + 64'd1) & mask) : v;
        // most significant digit ends up at the front, zero gives one digit
        do begin
            digits.push_front(itdt_pkg::CHAR_ZERO + 7'(mag % 64'd10));
            mag = mag / 64'd10;
        end while (mag != 64'd0);
        // anything above twelve counts as twelve
        room     = (len > itdt_pkg::MAX_ROOM) ? itdt_pkg::MAX_ROOM : len;
        text_len = digits.size() + (neg ? 1 : 0);
        // zero room, or text plus terminator too long, minus sign included
        if (room == 0 || text_len + 1 > room) begin
            chars.push_back('{itdt_pkg::CHAR_FAIL, 1'b1, 1'b1});
            return;
        end
        if (neg)
            chars.push_back('{itdt_pkg::CHAR_MINUS, 1'b0, 1'b0});
        foreach (digits[i])
            chars.push_back('{digits[i], 1'b0, (i == digits.size() - 1)});
    endfunction

    // --------------------------------------------------------------------
    // sender: one value per input transfer, valid stays high between
    // back-to-back values and only drops for an idle gap
    // --------------------------------------------------------------------
    task automatic send_value(input logic [31:0] value, input logic sgn,
                              input logic [3:0] len);
        if (tx_idle_on) begin
            while ($urandom_range(99) < 36) begin
                in_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_if.valid      <= 1'b1;
        in_if.value_bits <= value;
        in_if.is_signed  <= sgn;
        in_if.buffer_len <= len;
        // ready is sampled as it stood before the edge
        do @(posedge i_clk); while (!in_if.ready);
        predict_text(value, sgn, len, text_chars_pending);
    endtask

    // random value with a spread of digit counts; most buffers fit the
    // text with a little room to spare, the rest are random lengths
    task automatic send_random_value();
        logic [31:0] value;
        logic        sgn;
        logic [3:0]  len;
        t_text_char  probe[$];
        int unsigned fit_len;
        value = $urandom;
        if ($urandom_range(3) != 0)
            value = value >> $urandom_range(31, 0);
        sgn = 1'($urandom_range(1));
        if (sgn && $urandom_range(2) == 0)
            value = -value;
        if ($urandom_range(4) != 0) begin
            // room of fifteen never fails at this width, so it gives the text length
            predict_text(value, sgn, 4'd15, probe);
            fit_len = probe.size() + 1 + $urandom_range(3);
            len = (fit_len > 15) ? 4'd15 : 4'(fit_len);
        end else begin
            len = 4'($urandom_range(15));
        end
        send_value(value, sgn, len);
    endtask

    // sender holds off until every predicted character has been seen
    task automatic wait_text_drained();
        in_if.valid <= 1'b0;
        while (text_chars_pending.size() != 0)
            @(posedge i_clk);
    endtask

    // --------------------------------------------------------------------
    // receiver: ready toggles at random when idling is on
    // --------------------------------------------------------------------
    always @(posedge i_clk) begin
        out_if.ready <= !rx_idle_on || ($urandom_range(99) >= 36);
    end

    // --------------------------------------------------------------------
    // checker: every output transfer against the oldest prediction
    // --------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (text_chars_pending.size() == 0) begin
                $error("unexpected transfer char_code %0h status %0b last %0b",
                       out_if.char_code, out_if.status, out_if.last);
                mismatch_count++;
            end else begin
                want = text_chars_pending.pop_front();
                if (out_if.char_code !== want.char_code) begin
                    $error("char_code expected %0h actual %0h", want.char_code,
                           out_if.char_code);
                    mismatch_count++;
                end
                if (out_if.status !== want.status) begin
                    $error("status expected %0b actual %0b", want.status, out_if.status);
                    mismatch_count++;
                end
                if (out_if.last !== want.last) begin
                    $error("last expected %0b actual %0b", want.last, out_if.last);
                    mismatch_count++;
                end
            end
        end
    end

    // --------------------------------------------------------------------
    // tests
    // --------------------------------------------------------------------

    // field extremes, digit count edges and every way to fail
    task automatic test_directed_limits();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_value(32'd0,          1'b0, 4'd2);   // lone zero, just fits
        send_value(32'd0,          1'b1, 4'd1);   // zero with no room for terminator
        send_value(32'd0,          1'b0, 4'd0);   // zero length always fails
        send_value(32'hFFFF_FFFF,  1'b0, 4'd11);  // largest unsigned, exact fit
        send_value(32'hFFFF_FFFF,  1'b0, 4'd10);  // one short
        send_value(32'h8000_0000,  1'b1, 4'd12);  // most negative, full text
        send_value(32'h8000_0000,  1'b1, 4'd11);  // one short
        send_value(32'h8000_0000,  1'b0, 4'd15);  // same bits read unsigned
        send_value(32'h7FFF_FFFF,  1'b1, 4'd13);  // largest positive, room clamps
        send_value(32'hFFFF_FFFF,  1'b1, 4'd3);   // minus one
        send_value(32'hFFFF_FFFF,  1'b1, 4'd2);   // minus one, no terminator room
        send_value(32'hFFFF_FFFF,  1'b1, 4'd1);   // sign alone overflows a room of one
        send_value(32'hFFFF_FFFF,  1'b1, 4'd0);
        send_value(32'd9,          1'b0, 4'd2);
        send_value(32'd10,         1'b0, 4'd2);   // two digits need three
        send_value(32'd10,         1'b1, 4'd3);
        send_value(32'd99,         1'b0, 4'd3);
        send_value(32'd100,        1'b0, 4'd4);
        send_value(32'd999_999_999, 1'b0, 4'd10);
        send_value(32'd1_000_000_000, 1'b0, 4'd10); // ten digits need eleven
        send_value(32'hFFFF_FFF6,  1'b1, 4'd14);  // minus ten
        send_value(32'h5555_5555,  1'b0, 4'd15);
        send_value(32'hAAAA_AAAA,  1'b1, 4'd12);
    endtask

    // bulk random values with both sides idling
    task automatic test_random_with_idling();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (200) send_random_value();
    endtask

    // long stretch with valid and ready held high
    task automatic test_random_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (100) send_random_value();
    endtask

    // sender stops until the output is empty, then starts again cold
    task automatic test_pause_until_drained();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (15) send_random_value();
        wait_text_drained();
        repeat (15) send_random_value();
        wait_text_drained();
        send_value(32'h8000_0000, 1'b1, 4'd12);
        rx_idle_on = 1'b0;
        repeat (10) send_random_value();
    endtask

    // --------------------------------------------------------------------
    // sequence
    // --------------------------------------------------------------------
    initial begin
        mismatch_count   = 0;
        tx_idle_on       = 1'b0;
        rx_idle_on       = 1'b0;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.value_bits = '0;
        in_if.is_signed  = 1'b0;
        in_if.buffer_len = '0;
        out_if.ready     = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_limits();
        test_random_with_idling();
        test_random_back_to_back();
        test_pause_until_drained();

        // let the last texts come out, then watch for stray transfers
        in_if.valid <= 1'b0;
        rx_idle_on = 1'b1;
        while (text_chars_pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/itdt_pkg.sv
rtl/itdt_in_if.sv
rtl/itdt_out_if.sv
rtl/itdt_cell.sv
rtl/itdt_ser.sv
rtl/integer_to_decimal_text_unit.sv
rtl/itdt_chk.sv
test/testbench.sv
